FILE: rtl/lpr_pkg.sv
// Shared constants, types and helpers for the LRU page replacement block.
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int FAULT_W       = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef struct packed {
		logic en;
		logic was_valid;
		logic load;
	} lpr_touch_t;

	function automatic int idx_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

FILE: rtl/lru_page_replacement_top.sv
// LRU page replacement: usage notes
//   Channels: page references enter on in_valid/in_ready with page_number; one result
//   per reference leaves on out_valid/out_ready (hit, frame_index, evicted_valid,
//   evicted_page, fault_total). frames_in_use is written on cfg_valid/cfg_ready,
//   always ready, and should change only while no reference is in flight.
//   Each frame is a cell holding page, valid flag and exact recency rank; a
//   priority chain through the cells picks the first hit and the first empty frame.
//   Timing: one reference at a time. A hit or a fill runs from acceptance through
//   the lookup and update states and back to idle; the result is registered at commit.
//   A miss with every active frame full adds the oldest-frame tournament
//   between the lookup and update states.
//   Reset: every frame empty, ranks and fault total zero, frames_in_use 16.
//   Stall: results sit in an output register; the next reference is still taken
//   and runs up to its commit, where it holds until the register is free.
`timescale 1ns / 1ps

module lru_page_replacement_top import lpr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_W-1:0]             frames_in_use,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [PAGE_BITS-1:0]         page_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [idx_width(FRAMES)-1:0] frame_index,
	output logic                         evicted_valid,
	output logic [PAGE_BITS-1:0]         evicted_page,
	output logic [FAULT_W-1:0]           fault_total
);

	localparam int IDX_W  = idx_width(FRAMES);
	localparam int RANK_W = idx_width(FRAMES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_OLD  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0]           state_q;
	logic [CFG_W-1:0]     cfg_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 hit_any_q;
	logic                 empty_any_q;
	logic [FRAMES-1:0]    hit_oh_q;
	logic [FRAMES-1:0]    empty_oh_q;
	logic [FAULT_W-1:0]   fault_q;
	logic                 out_valid_q;

	logic [31:0]          n32;
	logic [FRAMES-1:0]    active;
	logic [FRAMES:0]      hit_chain;
	logic [FRAMES:0]      empty_chain;
	logic [FRAMES-1:0]    first_hit;
	logic [FRAMES-1:0]    first_empty;
	logic [FRAMES-1:0]    valid_v;
	logic [FRAMES-1:0]    sel_v;
	logic [RANK_W-1:0]    rank_v [FRAMES];
	logic [PAGE_BITS-1:0] page_v [FRAMES];

	logic                 old_done;
	logic [IDX_W-1:0]     old_idx;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     empty_idx;
	logic [IDX_W-1:0]     f_idx;
	logic [RANK_W-1:0]    sel_rank;
	logic [PAGE_BITS-1:0] sel_page;
	logic                 evict;
	logic                 out_free;
	logic                 commit;
	logic [FAULT_W-1:0]   fault_next;
	lpr_touch_t           touch;

	always_comb begin
		n32 = {{(32-CFG_W){1'b0}}, cfg_q};
		if (n32 == 32'd0) begin
			n32 = 32'd1;
		end else if (n32 > 32'(FRAMES)) begin
			n32 = 32'(FRAMES);
		end
	end

	assign hit_chain[0]   = 1'b0;
	assign empty_chain[0] = 1'b0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		assign active[i] = (32'(i) < n32);
		assign sel_v[i]  = (f_idx == IDX_W'(i));

		lpr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.RANK_W    (RANK_W),
			.RANK_MAX  (FRAMES - 1)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.look_page      (page_q),
			.active         (active[i]),
			.hit_seen_in    (hit_chain[i]),
			.empty_seen_in  (empty_chain[i]),
			.hit_seen_out   (hit_chain[i+1]),
			.empty_seen_out (empty_chain[i+1]),
			.first_hit      (first_hit[i]),
			.first_empty    (first_empty[i]),
			.touch          (touch),
			.sel            (sel_v[i]),
			.old_rank       (sel_rank),
			.new_page       (page_q),
			.valid          (valid_v[i]),
			.rank           (rank_v[i]),
			.page           (page_v[i])
		);
	end

	lpr_oldest #(
		.FRAMES (FRAMES),
		.RANK_W (RANK_W),
		.IDX_W  (IDX_W)
	) u_oldest (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LOOK),
		.active (active),
		.rank   (rank_v),
		.done   (old_done),
		.idx    (old_idx)
	);

	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			hit_idx   = hit_idx | (hit_oh_q[i] ? IDX_W'(i) : '0);
			empty_idx = empty_idx | (empty_oh_q[i] ? IDX_W'(i) : '0);
		end
	end

	always_comb begin
		priority if (hit_any_q) begin
			f_idx = hit_idx;
		end else if (empty_any_q) begin
			f_idx = empty_idx;
		end else begin
			f_idx = old_idx;
		end
	end

	always_comb begin
		sel_rank = '0;
		sel_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			sel_rank = sel_rank | (sel_v[i] ? rank_v[i] : '0);
			sel_page = sel_page | ((sel_v[i] && valid_v[i]) ? page_v[i] : '0);
		end
	end

	assign evict     = ~hit_any_q & ~empty_any_q;
	assign out_free  = ~out_valid_q | out_ready;
	assign commit    = (state_q == S_UPD) & out_free;
	assign fault_next = (!hit_any_q && fault_q != '1) ? fault_q + 1'b1 : fault_q;

	assign touch.en        = commit;
	assign touch.was_valid = hit_any_q | evict;
	assign touch.load      = ~hit_any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= CFG_RESET;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= frames_in_use;
			end
			if (commit) begin
				fault_q     <= fault_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= (hit_chain[FRAMES] || empty_chain[FRAMES]) ? S_UPD : S_OLD;
				end
				S_OLD: begin
					if (old_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			page_q <= page_number;
		end
		if (state_q == S_LOOK) begin
			hit_any_q   <= hit_chain[FRAMES];
			empty_any_q <= empty_chain[FRAMES];
			hit_oh_q    <= first_hit;
			empty_oh_q  <= first_empty;
		end
		if (commit) begin
			hit           <= hit_any_q;
			frame_index   <= f_idx;
			evicted_valid <= evict;
			evicted_page  <= evict ? sel_page : '0;
			fault_total   <= fault_next;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/lpr_cell.sv
// One page frame: page, valid flag and recency rank, with lookup chain links.
`timescale 1ns / 1ps

module lpr_cell import lpr_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int RANK_W    = 4,
	parameter int RANK_MAX  = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAGE_BITS-1:0] look_page,
	input  logic                 active,
	input  logic                 hit_seen_in,
	input  logic                 empty_seen_in,
	output logic                 hit_seen_out,
	output logic                 empty_seen_out,
	output logic                 first_hit,
	output logic                 first_empty,
	input  lpr_touch_t           touch,
	input  logic                 sel,
	input  logic [RANK_W-1:0]    old_rank,
	input  logic [PAGE_BITS-1:0] new_page,
	output logic                 valid,
	output logic [RANK_W-1:0]    rank,
	output logic [PAGE_BITS-1:0] page
);

	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 match;
	logic                 empty;
	logic                 age;

	assign match          = active & valid_q & (page_q == look_page);
	assign empty          = active & ~valid_q;
	assign first_hit      = match & ~hit_seen_in;
	assign first_empty    = empty & ~empty_seen_in;
	assign hit_seen_out   = hit_seen_in | match;
	assign empty_seen_out = empty_seen_in | empty;
	assign age            = valid_q & (~touch.was_valid | (rank_q < old_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (touch.en) begin
			if (sel) begin
				rank_q  <= '0;
				valid_q <= 1'b1;
			end else if (age && rank_q != RANK_W'(RANK_MAX)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (touch.en && touch.load && sel) begin
			page_q <= new_page;
		end
	end

	assign valid = valid_q;
	assign rank  = rank_q;
	assign page  = page_q;

endmodule

FILE: rtl/lpr_oldest.sv
// Registered 4:1 tournament that finds the oldest active frame over successive reduction steps.
`timescale 1ns / 1ps

module lpr_oldest import lpr_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF,
	parameter int RANK_W = 4,
	parameter int IDX_W  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FRAMES-1:0] active,
	input  logic [RANK_W-1:0] rank [FRAMES],
	output logic              done,
	output logic [IDX_W-1:0]  idx
);

	localparam int STEPS = ($clog2(FRAMES) + 1) / 2;

	typedef struct packed {
		logic              v;
		logic [RANK_W-1:0] r;
		logic [IDX_W-1:0]  i;
	} cand_t;

	cand_t      cand_q [FRAMES];
	cand_t      pad    [4*FRAMES];
	cand_t      nxt    [FRAMES];
	logic [1:0] cnt_q;

	function automatic cand_t pick(input cand_t a, input cand_t b);
		if (!b.v || (a.v && a.r >= b.r)) begin
			return a;
		end
		return b;
	endfunction

	for (genvar i = 0; i < 4*FRAMES; i++) begin : g_pad
		if (i < FRAMES) begin : g_in
			assign pad[i] = cand_q[i];
		end else begin : g_out
			assign pad[i] = '0;
		end
	end

	for (genvar j = 0; j < FRAMES; j++) begin : g_red
		assign nxt[j] = pick(pick(pad[4*j], pad[4*j+1]), pick(pad[4*j+2], pad[4*j+3]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'(STEPS);
		end else if (start) begin
			cnt_q <= '0;
		end else if (cnt_q != 2'(STEPS)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < FRAMES; i++) begin
				cand_q[i].v <= active[i];
				cand_q[i].r <= rank[i];
				cand_q[i].i <= IDX_W'(i);
			end
		end else if (cnt_q != 2'(STEPS)) begin
			cand_q <= nxt;
		end
	end

	assign done = (cnt_q == 2'(STEPS));
	assign idx  = cand_q[0].i;

endmodule

FILE: rtl/lpr_checker.sv
// Port-level checks for the LRU page replacement block, bound to the top level.
`timescale 1ns / 1ps

module lpr_checker import lpr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic                 evicted_valid,
	input logic [PAGE_BITS-1:0] evicted_page,
	input logic [FAULT_W-1:0]   fault_total
);

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("eviction reported on a hit");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page not zero without eviction");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> fault_total != '0)
		else $error("fault transaction with zero fault total");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fault_total) && $stable(hit))
		else $error("result dropped or changed while stalled");

endmodule

bind lru_page_replacement_top lpr_checker #(
	.FRAMES    (FRAMES),
	.PAGE_BITS (PAGE_BITS)
) u_lpr_checker (.*);

FILE: dv/lru_page_replacement_top_tb.sv
// Self-checking testbench for the LRU page replacement block, with its own page frame predictor.
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;
	import lpr_pkg::*;

	localparam int FR         = FRAMES_DEF;
	localparam int PB         = PAGE_BITS_DEF;
	localparam int FIW        = $clog2(FRAMES_DEF);
	localparam int CYCLE_CAP  = 400000;

	typedef struct packed {
		logic           hit;
		logic [FIW-1:0] frame;
		logic           evicted;
		logic [PB-1:0]  evicted_pg;
		logic [FAULT_W-1:0] faults;
	} page_lookup_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    frames_in_use = CFG_RESET;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [PB-1:0]       page_number = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                hit;
	logic [FIW-1:0]      frame_index;
	logic                evicted_valid;
	logic [PB-1:0]       evicted_page;
	logic [FAULT_W-1:0]  fault_total;

	logic [PB-1:0]       frame_pg [FR];
	bit                  frame_held [FR];
	logic [FIW-1:0]      frame_age [FR];
	logic [FAULT_W-1:0]  fault_tally = '0;
	logic [CFG_W-1:0]    cfg_frames = CFG_RESET;

	page_lookup_t        expected_lookups [$];
	int                  mismatch_count = 0;
	int                  cycle_count = 0;
	int                  result_count = 0;
	bit                  idle_on = 1'b0;
	int                  stall_left = 0;

	lru_page_replacement_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.frames_in_use (frames_in_use),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < FR; i++) begin
			frame_pg[i] = '0;
			frame_held[i] = 1'b0;
			frame_age[i] = '0;
		end
	end

	function automatic void promote_frame(input int f, input bit was_held);
		logic [FIW-1:0] prior;
		prior = frame_age[f];
		for (int i = 0; i < FR; i++) begin
			if (i != f && frame_held[i] && (!was_held || frame_age[i] < prior)
					&& frame_age[i] != FR - 1)
				frame_age[i]++;
		end
		frame_age[f] = '0;
	endfunction

	function automatic page_lookup_t resolve_reference(input logic [PB-1:0] page);
		page_lookup_t r;
		int n;
		int f;
		n = (cfg_frames == 0) ? 1 : ((cfg_frames > FR) ? FR : int'(cfg_frames));
		r = '0;
		f = -1;
		for (int i = 0; i < n; i++) begin
			if (f < 0 && frame_held[i] && frame_pg[i] == page)
				f = i;
		end
		if (f >= 0) begin
			r.hit = 1'b1;
			promote_frame(f, 1'b1);
		end else begin
			if (fault_tally != '1)
				fault_tally++;
			for (int i = 0; i < n; i++) begin
				if (f < 0 && !frame_held[i])
					f = i;
			end
			if (f >= 0) begin
				frame_held[f] = 1'b1;
				frame_pg[f] = page;
				promote_frame(f, 1'b0);
			end else begin
				f = 0;
				for (int i = 1; i < n; i++) begin
					if (frame_age[i] > frame_age[f])
						f = i;
				end
				r.evicted = 1'b1;
				r.evicted_pg = frame_pg[f];
				frame_pg[f] = page;
				promote_frame(f, 1'b1);
			end
		end
		r.frame = f[FIW-1:0];
		r.faults = fault_tally;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("[%0t] result %0d: %s got %0h, expected %0h", $time, result_count, field,
			got, want);
	endtask

	task automatic send_page(input logic [PB-1:0] page);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		page_number <= page;
		do @(posedge clk); while (!in_ready);
		expected_lookups.push_back(resolve_reference(page));
	endtask

	task automatic write_frame_count(input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		wait (expected_lookups.size() == 0);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		frames_in_use <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_frames = value;
	endtask

	task automatic run_working_set(input logic [CFG_W-1:0] count_cfg, input int span,
			input int items, input bit allow_idle);
		logic [PB-1:0] base;
		write_frame_count(count_cfg);
		base = PB'($urandom_range(0, (1 << PB) - 1 - span));
		for (int k = 0; k < items; k++) begin
			idle_on = allow_idle && ((k / 40) % 3 != 2);
			if ($urandom_range(0, 99) < 85)
				send_page(PB'(base + $urandom_range(0, span - 1)));
			else
				send_page(PB'($urandom));
		end
	endtask

	task automatic test_fill_and_hit();
		idle_on = 1'b1;
		send_page('0);
		send_page('1);
		send_page('0);
		send_page(16'h5555);
		send_page(16'hAAAA);
	endtask

	task automatic test_replacement_order();
		write_frame_count(5'd3);
		send_page(16'h1234);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'h7777);
		send_page(16'hAAAA);
		send_page(16'h1234);
	endtask

	task automatic test_frame_count_limits();
		write_frame_count(5'd0);
		send_page(16'h00FF);
		send_page(16'h00FF);
		send_page(16'hFF00);
		write_frame_count(5'd31);
		send_page(16'hAAAA);
		send_page(16'h8001);
		send_page(16'h7FFE);
		write_frame_count(5'd17);
		send_page(16'h00FF);
	endtask

	task automatic test_random_mix();
		run_working_set(5'd16, 22, 120, 1'b1);
		run_working_set(5'd1, 3, 110, 1'b1);
		run_working_set(5'd4, 7, 120, 1'b1);
		run_working_set(5'd9, 12, 120, 1'b1);
		run_working_set(5'd31, 26, 120, 1'b1);
		run_working_set(5'd0, 2, 100, 1'b1);
		run_working_set(5'd12, 40, 120, 1'b1);
		run_working_set(5'd7, 9, 120, 1'b1);
	endtask

	task automatic test_back_to_back();
		run_working_set(5'd16, 20, 170, 1'b0);
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		page_lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (expected_lookups.size() == 0) begin
				report_mismatch("transaction with nothing pending", '0, '0);
			end else begin
				want = expected_lookups.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				if (frame_index !== want.frame)
					report_mismatch("frame_index", 32'(frame_index), 32'(want.frame));
				if (evicted_valid !== want.evicted)
					report_mismatch("evicted_valid", 32'(evicted_valid),
						32'(want.evicted));
				if (evicted_page !== want.evicted_pg)
					report_mismatch("evicted_page", 32'(evicted_page),
						32'(want.evicted_pg));
				if (fault_total !== want.faults)
					report_mismatch("fault_total", fault_total, want.faults);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("lru_page_replacement_top regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_and_hit();
		test_replacement_order();
		test_frame_count_limits();
		test_random_mix();
		test_back_to_back();
		in_valid <= 1'b0;
		wait (expected_lookups.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("lru_page_replacement_top regression: pass");
		end else begin
			$display("lru_page_replacement_top regression: fail");
		end
		$finish;
	end

endmodule
